FILE: rtl/usks_pkg.sv
// Shared types, key codes and digit helpers for the keystroke sequencer.
package usks_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CP_BITS     = 21;
    localparam int DEC_DIGITS  = 7;
    localparam int MAX_DIGITS  = 8;

    localparam logic [2:0] MOD_NONE  = 3'b000;
    localparam logic [2:0] MOD_CTRL  = 3'b001;
    localparam logic [2:0] MOD_SHIFT = 3'b010;
    localparam logic [2:0] MOD_ALT   = 3'b100;

    localparam logic [7:0] KEY_NONE       = 8'h00;
    localparam logic [7:0] KEY_U          = 8'h18;
    localparam logic [7:0] KEY_ENTER      = 8'h28;
    localparam logic [7:0] KEY_KP_PLUS    = 8'h57;
    localparam logic [7:0] KEY_KP_ZERO    = 8'h62;
    localparam logic [7:0] KEY_ZERO       = 8'h27;
    localparam logic [7:0] KEY_DIGIT_BASE = 8'h1D;
    localparam logic [7:0] KEY_KP_BASE    = 8'h58;
    localparam logic [7:0] LETTER_OFFSET  = 8'h06;

    localparam logic [20:0] CP_PLANE1  = 21'h10000;
    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;

    typedef enum logic [1:0] {
        METH_UNIX    = 2'd0,
        METH_WIN_DEC = 2'd1,
        METH_WIN_HEX = 2'd2,
        METH_MAC     = 2'd3
    } t_method;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PRE,
        B_DIG,
        B_TAIL
    } t_back_state;

    typedef struct packed {
        t_method     meth;
        logic [31:0] digs;
        logic [3:0]  ndig;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] digit_key(input logic [3:0] d, input logic keypad);
        logic [7:0] dz;
        logic [7:0] k;
        dz = {4'b0000, d};
        if (d >= 4'd10) begin
            k = dz - LETTER_OFFSET;
        end else if (d == 4'd0) begin
            k = keypad ? KEY_KP_ZERO : KEY_ZERO;
        end else begin
            k = dz + (keypad ? KEY_KP_BASE : KEY_DIGIT_BASE);
        end
        return k;
    endfunction

    // Significant digit count, at least one.
    function automatic logic [3:0] digit_count(input logic [31:0] digs);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (digs[i*4 +: 4] != 4'h0) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/unicode_keystroke_sequencer_unit.sv
// Top level of the code point to keyboard report sequencer.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------------
//  config   | in        | i_cfg_wr_en                | i_cfg_wr_data (input method)
//  input    | in        | i_in_valid / o_in_stall    | i_code_point
//  output   | out       | o_out_valid / i_out_stall  | o_modifier_bits, o_key_code,
//           |           |                            | o_last_report
//
// Unless the output stalls, the back end emits one report a cycle: prefix, 2 or 3 per digit,
// tail; 27 at most. The front end takes a word, then pushes it into the queue for the hex
// methods, or after a binary to BCD conversion for the decimal method.
// A two-entry queue lets the front end convert the next word while reports play out.
// Reset is synchronous, active low, and clears control state only.
// An output stall holds the report register and the back end; the front end stalls
// its input from the accepting edge until the word is pushed into the queue.
module unicode_keystroke_sequencer_unit #(
    parameter int QUEUE_DEPTH = usks_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [20:0] i_code_point,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_modifier_bits,
    output logic [7:0]  o_key_code,
    output logic        o_last_report
);

    usks_pkg::t_method  r_method;
    usks_pkg::t_entry   push_entry;
    usks_pkg::t_entry   head_entry;
    usks_pkg::t_q_stat  q_stat;
    logic               q_push;
    logic               q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= usks_pkg::METH_UNIX;
        end else if (i_cfg_wr_en) begin
            r_method <= usks_pkg::t_method'(i_cfg_wr_data);
        end
    end

    usks_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_method     (r_method),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_code_point (i_code_point),
        .o_push       (q_push),
        .o_entry      (push_entry),
        .i_q_stat     (q_stat)
    );

    usks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_entry (head_entry),
        .o_stat  (q_stat)
    );

    usks_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (head_entry),
        .i_q_stat        (q_stat),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_modifier_bits (o_modifier_bits),
        .o_key_code      (o_key_code),
        .o_last_report   (o_last_report)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_last_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_report) |-> (o_modifier_bits == 3'd0 && o_key_code == 8'd0))
        else $error("final report not cleared");

endmodule

FILE: rtl/usks_front.sv
// Front end: accepts a code point and turns it into a digit string for the queue.
module usks_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  usks_pkg::t_method        i_method,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [20:0]              i_code_point,
    output logic                     o_push,
    output usks_pkg::t_entry         o_entry,
    input  usks_pkg::t_q_stat        i_q_stat
);

    localparam int BCD_W = usks_pkg::DEC_DIGITS * 4;

    usks_pkg::t_front_state r_state, n_state;
    usks_pkg::t_method      r_meth;
    logic [20:0]            r_cp;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       adj;
    logic [4:0]             r_cnt;
    logic                   accept;
    logic                   conv_done;
    logic [20:0]            cp_off;

    assign accept    = i_in_valid && !o_in_stall;
    assign conv_done = (r_cnt == 5'(usks_pkg::CP_BITS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            usks_pkg::F_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_method == usks_pkg::METH_WIN_DEC) ? usks_pkg::F_CONV
                                                                  : usks_pkg::F_PUSH;
                end
            end
            usks_pkg::F_CONV: begin
                if (conv_done) n_state = usks_pkg::F_PUSH;
            end
            usks_pkg::F_PUSH: begin
                if (!i_q_stat.full) n_state = usks_pkg::F_IDLE;
            end
            default: n_state = usks_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != usks_pkg::F_IDLE);
        o_push     = (r_state == usks_pkg::F_PUSH) && !i_q_stat.full;
    end

    // Shift-and-add-3 binary to BCD, one bit a cycle.
    always_comb begin
        for (int i = 0; i < usks_pkg::DEC_DIGITS; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? (r_bcd[i*4 +: 4] + 4'd3)
                                                      : r_bcd[i*4 +: 4];
        end
    end

    always_comb begin
        cp_off        = r_cp - usks_pkg::CP_PLANE1;
        o_entry.meth  = r_meth;
        o_entry.digs  = {11'b0, r_cp};
        o_entry.ndig  = usks_pkg::digit_count({11'b0, r_cp});
        unique case (r_meth)
            usks_pkg::METH_WIN_DEC: begin
                o_entry.digs = {4'b0000, r_bcd};
                o_entry.ndig = usks_pkg::digit_count({4'b0000, r_bcd});
            end
            usks_pkg::METH_MAC: begin
                if (r_cp < usks_pkg::CP_PLANE1) begin
                    o_entry.digs = {16'b0, r_cp[15:0]};
                    o_entry.ndig = 4'd4;
                end else begin
                    o_entry.digs = {usks_pkg::SURR_HI_TAG, cp_off[19:10],
                                    usks_pkg::SURR_LO_TAG, cp_off[9:0]};
                    o_entry.ndig = 4'd8;
                end
            end
            default: begin
                o_entry.digs = {11'b0, r_cp};
                o_entry.ndig = usks_pkg::digit_count({11'b0, r_cp});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usks_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cp   <= i_code_point;
            r_meth <= i_method;
            r_bcd  <= '0;
            r_cnt  <= '0;
        end else if (r_state == usks_pkg::F_CONV) begin
            r_bcd <= {adj[BCD_W-2:0], r_cp[20]};
            r_cp  <= {r_cp[19:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
        end
    end

endmodule

FILE: rtl/usks_queue.sv
// Short queue of digit strings between front and back end.
module usks_queue #(
    parameter int DEPTH = usks_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  usks_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output usks_pkg::t_entry  o_entry,
    output usks_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    usks_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= wrap_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= wrap_inc(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

FILE: rtl/usks_back.sv
// Back end: plays one digit string out as a run of keyboard reports.
module usks_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usks_pkg::t_entry  i_entry,
    input  usks_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_modifier_bits,
    output logic [7:0]        o_key_code,
    output logic              o_last_report
);

    usks_pkg::t_back_state r_state, n_state;
    usks_pkg::t_method     r_meth;
    logic [31:0]           r_digs;
    logic [2:0]            r_didx, n_didx;
    logic [2:0]            r_step, n_step;
    logic [1:0]            r_sub, n_sub;
    logic                  r_ovalid;
    logic [2:0]            r_mod;
    logic [7:0]            r_key;
    logic                  r_last;

    logic                  adv;
    logic [2:0]            rep_mod;
    logic [7:0]            rep_key;
    logic                  rep_last;
    logic [2:0]            pre_last;
    logic [1:0]            dig_last;
    logic [2:0]            dig_mod;
    logic [7:0]            dig_key;
    logic                  keypad;

    assign adv    = (r_state != usks_pkg::B_IDLE) && (!r_ovalid || !i_out_stall);
    assign o_pop  = (r_state == usks_pkg::B_IDLE) && !i_q_stat.empty;
    assign keypad = (r_meth == usks_pkg::METH_WIN_DEC) || (r_meth == usks_pkg::METH_WIN_HEX);
    assign dig_key = usks_pkg::digit_key(r_digs[{r_didx, 2'b00} +: 4], keypad);

    always_comb begin
        pre_last = 3'd3;
        dig_last = 2'd2;
        dig_mod  = usks_pkg::MOD_ALT;
        unique case (r_meth)
            usks_pkg::METH_UNIX: begin
                pre_last = 3'd6;
                dig_mod  = usks_pkg::MOD_NONE;
            end
            usks_pkg::METH_WIN_DEC: dig_last = 2'd1;
            usks_pkg::METH_MAC:     pre_last = 3'd1;
            default: pre_last = 3'd3;
        endcase
    end

    // Report for the current step.
    always_comb begin
        rep_mod  = usks_pkg::MOD_NONE;
        rep_key  = usks_pkg::KEY_NONE;
        rep_last = 1'b0;
        unique case (r_state)
            usks_pkg::B_PRE: begin
                if (r_meth == usks_pkg::METH_UNIX) begin
                    case (r_step)
                        3'd1, 3'd5: rep_mod = usks_pkg::MOD_CTRL;
                        3'd2, 3'd4: rep_mod = usks_pkg::MOD_CTRL | usks_pkg::MOD_SHIFT;
                        3'd3: begin
                            rep_mod = usks_pkg::MOD_CTRL | usks_pkg::MOD_SHIFT;
                            rep_key = usks_pkg::KEY_U;
                        end
                        default: rep_mod = usks_pkg::MOD_NONE;
                    endcase
                end else if (r_step != 3'd0) begin
                    rep_mod = usks_pkg::MOD_ALT;
                    if (r_step == 3'd2) begin
                        rep_key = (r_meth == usks_pkg::METH_WIN_DEC) ? usks_pkg::KEY_KP_ZERO
                                                                     : usks_pkg::KEY_KP_PLUS;
                    end
                end
            end
            usks_pkg::B_DIG: begin
                rep_mod = dig_mod;
                // decimal digits skip the leading modifier report
                if (r_meth == usks_pkg::METH_WIN_DEC) begin
                    if (r_sub == 2'd0) rep_key = dig_key;
                end else if (r_sub == 2'd1) begin
                    rep_key = dig_key;
                end
            end
            usks_pkg::B_TAIL: begin
                if (r_meth == usks_pkg::METH_UNIX && r_step == 3'd0) begin
                    rep_key = usks_pkg::KEY_ENTER;
                end else begin
                    rep_last = 1'b1;
                end
            end
            default: rep_last = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sub   = r_sub;
        n_didx  = r_didx;
        unique case (r_state)
            usks_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = usks_pkg::B_PRE;
                    n_step  = 3'd0;
                    n_sub   = 2'd0;
                    n_didx  = 3'(i_entry.ndig - 4'd1);
                end
            end
            usks_pkg::B_PRE: begin
                if (adv) begin
                    if (r_step == pre_last) begin
                        n_state = usks_pkg::B_DIG;
                        n_sub   = 2'd0;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            usks_pkg::B_DIG: begin
                if (adv) begin
                    if (r_sub == dig_last) begin
                        n_sub = 2'd0;
                        if (r_didx == 3'd0) begin
                            n_state = usks_pkg::B_TAIL;
                            n_step  = 3'd0;
                        end else begin
                            n_didx = r_didx - 3'd1;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            usks_pkg::B_TAIL: begin
                if (adv) begin
                    if (rep_last) n_state = usks_pkg::B_IDLE;
                    else          n_step  = r_step + 3'd1;
                end
            end
            default: n_state = usks_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= usks_pkg::B_IDLE;
            r_step   <= '0;
            r_sub    <= '0;
            r_didx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sub   <= n_sub;
            r_didx  <= n_didx;
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_meth <= i_entry.meth;
            r_digs <= i_entry.digs;
        end
        if (adv) begin
            r_mod  <= rep_mod;
            r_key  <= rep_key;
            r_last <= rep_last;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_modifier_bits = r_mod;
    assign o_key_code      = r_key;
    assign o_last_report   = r_last;

endmodule
